@@ hw/rtl/pec_pkg.sv @@
// Shared types and command/status structs for the polygon edge clipper.
package pec_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIDE_P,
        ST_SIDE_V,
        ST_SIDE_F,
        ST_DECIDE,
        ST_PICK,
        ST_MUL_X,
        ST_DIV_X,
        ST_MUL_Y,
        ST_DIV_Y,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SIDE_PREV,
        SIDE_CUR,
        SIDE_FIRST
    } side_sel_t;

    typedef enum logic [1:0] {
        KIND_PREV,
        KIND_CUR,
        KIND_ISECT,
        KIND_MARK
    } kind_t;

    // pending result slots, in output order
    localparam int SLOT_PREV   = 0;
    localparam int SLOT_ISECT0 = 1;
    localparam int SLOT_CUR    = 2;
    localparam int SLOT_ISECT1 = 3;
    localparam int SLOT_MARK   = 4;
    localparam int NUM_SLOTS   = 5;

    localparam logic [1:0] REG_POINT_X  = 2'd0;
    localparam logic [1:0] REG_POINT_Y  = 2'd1;
    localparam logic [1:0] REG_NORMAL_X = 2'd2;
    localparam logic [1:0] REG_NORMAL_Y = 2'd3;

    typedef struct packed {
        logic      cap;
        logic      side_we;
        side_sel_t side_sel;
        logic      mul_go;
        logic      edge_close;   // 0: prev->cur, 1: cur->first
        logic      coord_y;
        logic      div_step;
        logic      isx_we;
        logic      isy_we;
        logic      emit;
        kind_t     kind;
        logic      run_end;
        logic      poly_end;
        logic      commit;
    } cmd_t;

    typedef struct packed {
        logic seen;
        logic fin;
        logic in_p;
        logic in_v;
        logic in_f;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

@@ hw/rtl/polygon_edge_clipper_core.sv @@
// Polygon edge clipper top level: one clip stage against a configurable line.
// One vertex item is taken at a time. An item that causes no result passes through
// the accept, the three side tests, the slot decision and the return to idle. Each
// result adds a slot pick and an emit (plus any wait on result_ready), and each edge
// crossing adds the runs of the bit-serial restoring divider that forms the x and
// y intersection quotients in turn. A vertex item produces up to three results; the
// result register lets the next vertex be taken while the last result is still
// waiting to be read.
module polygon_edge_clipper_core
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_data,
    input  logic                         vertex_valid,
    output logic                         vertex_ready,
    input  logic signed [COORD_BITS-1:0] vertex_x,
    input  logic signed [COORD_BITS-1:0] vertex_y,
    input  logic                         final_vertex,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic                         has_vertex,
    output logic                         run_end,
    output logic                         polygon_end
);

    pec_pkg::cmd_t  cmd;
    pec_pkg::stat_t stat;

    pec_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    pec_dp
    #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .final_vertex (final_vertex),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_x        (out_x),
        .out_y        (out_y),
        .has_vertex   (has_vertex),
        .run_end      (run_end),
        .polygon_end  (polygon_end),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

@@ hw/rtl/pec_ctrl.sv @@
// Sequencer for the clipper: side tests, result slots, intersection steps.
module pec_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           vertex_valid,
    output logic           vertex_ready,
    input  pec_pkg::stat_t stat,
    output pec_pkg::cmd_t  cmd
);

    pec_pkg::state_t state_reg, state_next;
    logic [pec_pkg::NUM_SLOTS-1:0] pend_reg, pend_next;
    logic [pec_pkg::NUM_SLOTS-1:0] cur_bit;
    logic [pec_pkg::NUM_SLOTS-1:0] rest;
    logic cur_isect;
    pec_pkg::kind_t cur_kind;

    // lowest pending slot goes out first
    assign cur_bit   = pend_reg & (~pend_reg + pec_pkg::NUM_SLOTS'(1));
    assign rest      = pend_reg & ~cur_bit;
    assign cur_isect = cur_bit[pec_pkg::SLOT_ISECT0] | cur_bit[pec_pkg::SLOT_ISECT1];

    always_comb
    begin
        priority if (cur_bit[pec_pkg::SLOT_PREV])
            cur_kind = pec_pkg::KIND_PREV;
        else if (cur_bit[pec_pkg::SLOT_CUR])
            cur_kind = pec_pkg::KIND_CUR;
        else if (cur_isect)
            cur_kind = pec_pkg::KIND_ISECT;
        else
            cur_kind = pec_pkg::KIND_MARK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pec_pkg::ST_IDLE;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        unique case (state_reg)
            pec_pkg::ST_IDLE:
                if (vertex_valid)
                    state_next = pec_pkg::ST_SIDE_P;
            pec_pkg::ST_SIDE_P:
                state_next = pec_pkg::ST_SIDE_V;
            pec_pkg::ST_SIDE_V:
                state_next = pec_pkg::ST_SIDE_F;
            pec_pkg::ST_SIDE_F:
                state_next = pec_pkg::ST_DECIDE;
            pec_pkg::ST_DECIDE:
            begin
                pend_next[pec_pkg::SLOT_PREV]   = stat.seen & stat.in_p;
                pend_next[pec_pkg::SLOT_ISECT0] = stat.seen & (stat.in_p ^ stat.in_v);
                pend_next[pec_pkg::SLOT_CUR]    = stat.fin & stat.in_v;
                pend_next[pec_pkg::SLOT_ISECT1] = stat.fin & (stat.in_v ^ stat.in_f);
                pend_next[pec_pkg::SLOT_MARK]   = stat.fin & ~stat.in_v
                    & ~(stat.seen & (stat.in_p | (stat.in_p ^ stat.in_v)))
                    & ~(stat.in_v ^ stat.in_f);
                state_next = pec_pkg::ST_PICK;
            end
            pec_pkg::ST_PICK:
            begin
                if (pend_reg == '0)
                    state_next = pec_pkg::ST_IDLE;
                else if (cur_isect)
                    state_next = pec_pkg::ST_MUL_X;
                else
                    state_next = pec_pkg::ST_EMIT;
            end
            pec_pkg::ST_MUL_X:
                state_next = pec_pkg::ST_DIV_X;
            pec_pkg::ST_DIV_X:
                if (stat.div_done)
                    state_next = pec_pkg::ST_MUL_Y;
            pec_pkg::ST_MUL_Y:
                state_next = pec_pkg::ST_DIV_Y;
            pec_pkg::ST_DIV_Y:
                if (stat.div_done)
                    state_next = pec_pkg::ST_EMIT;
            pec_pkg::ST_EMIT:
                if (stat.out_free)
                begin
                    pend_next  = rest;
                    state_next = pec_pkg::ST_PICK;
                end
            default:
                state_next = pec_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.side_sel   = pec_pkg::SIDE_PREV;
        cmd.kind       = cur_kind;
        cmd.edge_close = cur_bit[pec_pkg::SLOT_ISECT1];
        cmd.run_end    = (rest == '0);
        cmd.poly_end   = (rest == '0) & stat.fin;
        vertex_ready   = 1'b0;
        unique case (state_reg)
            pec_pkg::ST_IDLE:
            begin
                vertex_ready = 1'b1;
                cmd.cap      = vertex_valid;
            end
            pec_pkg::ST_SIDE_P:
            begin
                cmd.side_we  = 1'b1;
                cmd.side_sel = pec_pkg::SIDE_PREV;
            end
            pec_pkg::ST_SIDE_V:
            begin
                cmd.side_we  = 1'b1;
                cmd.side_sel = pec_pkg::SIDE_CUR;
            end
            pec_pkg::ST_SIDE_F:
            begin
                cmd.side_we  = 1'b1;
                cmd.side_sel = pec_pkg::SIDE_FIRST;
            end
            pec_pkg::ST_DECIDE:
                cmd.commit = 1'b0;
            pec_pkg::ST_PICK:
                cmd.commit = (pend_reg == '0);
            pec_pkg::ST_MUL_X:
                cmd.mul_go = 1'b1;
            pec_pkg::ST_DIV_X:
            begin
                cmd.isx_we   = stat.div_done;
                cmd.div_step = ~stat.div_done;
            end
            pec_pkg::ST_MUL_Y:
            begin
                cmd.mul_go  = 1'b1;
                cmd.coord_y = 1'b1;
            end
            pec_pkg::ST_DIV_Y:
            begin
                cmd.coord_y  = 1'b1;
                cmd.isy_we   = stat.div_done;
                cmd.div_step = ~stat.div_done;
            end
            pec_pkg::ST_EMIT:
                cmd.emit = stat.out_free;
            default:
                cmd.commit = 1'b0;
        endcase
    end

endmodule

@@ hw/rtl/pec_dp.sv @@
// Datapath: config and vertex registers, side test, intersection divider, output register.
module pec_dp
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_data,
    input  logic signed [COORD_BITS-1:0] vertex_x,
    input  logic signed [COORD_BITS-1:0] vertex_y,
    input  logic                         final_vertex,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic                         has_vertex,
    output logic                         run_end,
    output logic                         polygon_end,
    input  pec_pkg::cmd_t                cmd,
    output pec_pkg::stat_t               stat
);

    localparam int C   = COORD_BITS;
    localparam int DW  = C + 1;
    localparam int SW  = 2 * C + 2;
    localparam int DNW = 2 * C + 3;
    localparam int NW  = 3 * C + 3;
    localparam int QW  = C + 1;
    localparam int RW  = C + 3;
    localparam int CNW = $clog2(QW + 1);
    localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (C - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

    logic signed [C-1:0] px_reg, py_reg, nx_reg, ny_reg;
    logic signed [C-1:0] fx_reg, fy_reg, qx_reg, qy_reg, vx_reg, vy_reg;
    logic                fin_reg, seen_reg;
    logic signed [SW-1:0] sp_reg, sv_reg, sf_reg;
    logic signed [C-1:0] ix_reg, iy_reg;
    logic [NW-1:0]       rem_reg, dsh_reg;
    logic [DNW-1:0]      den_reg;
    logic [QW-1:0]       q_reg;
    logic [CNW-1:0]      cnt_reg;
    logic                neg_reg;
    logic                ov_reg, has_reg, re_reg, pe_reg;
    logic signed [C-1:0] ox_reg, oy_reg;

    // side test
    logic signed [C-1:0]  sx, sy;
    logic signed [DW-1:0] dx, dy;
    logic signed [SW-1:0] side_val;

    always_comb
    begin
        unique case (cmd.side_sel)
            pec_pkg::SIDE_PREV:
            begin
                sx = qx_reg;
                sy = qy_reg;
            end
            pec_pkg::SIDE_CUR:
            begin
                sx = vx_reg;
                sy = vy_reg;
            end
            default:
            begin
                sx = fx_reg;
                sy = fy_reg;
            end
        endcase
    end

    assign dx = DW'(sx) - DW'(px_reg);
    assign dy = DW'(sy) - DW'(py_reg);
    assign side_val = SW'(dx) * SW'(nx_reg) + SW'(dy) * SW'(ny_reg);

    // intersection operands
    logic signed [SW-1:0]  sa, sb;
    logic signed [C-1:0]   ac, bc;
    logic signed [DW-1:0]  diff;
    logic signed [NW-1:0]  num;
    logic signed [DNW-1:0] den;
    logic [NW-1:0]         num_abs;
    logic [DNW-1:0]        den_abs;

    always_comb
    begin
        sa = cmd.edge_close ? sv_reg : sp_reg;
        sb = cmd.edge_close ? sf_reg : sv_reg;
        if (cmd.edge_close)
        begin
            ac = cmd.coord_y ? vy_reg : vx_reg;
            bc = cmd.coord_y ? fy_reg : fx_reg;
        end
        else
        begin
            ac = cmd.coord_y ? qy_reg : qx_reg;
            bc = cmd.coord_y ? vy_reg : vx_reg;
        end
    end

    assign diff    = DW'(bc) - DW'(ac);
    assign num     = NW'(sa) * NW'(diff);
    assign den     = DNW'(sa) - DNW'(sb);
    assign num_abs = num[NW-1] ? NW'(-num) : NW'(num);
    assign den_abs = den[DNW-1] ? DNW'(-den) : DNW'(den);

    // rounded quotient and saturated coordinate
    logic              rnd;
    logic [QW:0]       qr;
    logic signed [RW-1:0] qval, csum;
    logic signed [C-1:0]  csat;

    assign rnd  = ((NW + 1)'(rem_reg) << 1) >= (NW + 1)'(den_reg);
    assign qr   = (QW + 1)'(q_reg) + (QW + 1)'(rnd);
    assign qval = neg_reg ? -RW'(qr) : RW'(qr);
    assign csum = RW'(ac) + qval;

    always_comb
    begin
        priority if (csum > SAT_HI)
            csat = SAT_HI[C-1:0];
        else if (csum < SAT_LO)
            csat = SAT_LO[C-1:0];
        else
            csat = csum[C-1:0];
    end

    logic rem_ge;
    assign rem_ge = rem_reg >= dsh_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg   <= '0;
            py_reg   <= '0;
            nx_reg   <= C'(1) << FRAC_BITS;
            ny_reg   <= '0;
            fx_reg   <= '0;
            fy_reg   <= '0;
            qx_reg   <= '0;
            qy_reg   <= '0;
            seen_reg <= 1'b0;
            ov_reg   <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pec_pkg::REG_POINT_X:  px_reg <= cfg_data;
                    pec_pkg::REG_POINT_Y:  py_reg <= cfg_data;
                    pec_pkg::REG_NORMAL_X: nx_reg <= cfg_data;
                    default:               ny_reg <= cfg_data;
                endcase
            end
            if (cmd.cap && !seen_reg)
            begin
                fx_reg <= vertex_x;
                fy_reg <= vertex_y;
            end
            if (cmd.commit)
            begin
                qx_reg   <= vx_reg;
                qy_reg   <= vy_reg;
                seen_reg <= ~fin_reg;
            end
            if (cmd.mul_go)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + CNW'(1);
            if (cmd.emit)
                ov_reg <= 1'b1;
            else if (result_ready)
                ov_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            vx_reg  <= vertex_x;
            vy_reg  <= vertex_y;
            fin_reg <= final_vertex;
        end
        if (cmd.side_we)
        begin
            unique case (cmd.side_sel)
                pec_pkg::SIDE_PREV: sp_reg <= side_val;
                pec_pkg::SIDE_CUR:  sv_reg <= side_val;
                default:            sf_reg <= side_val;
            endcase
        end
        if (cmd.mul_go)
        begin
            rem_reg <= num_abs;
            dsh_reg <= NW'(den_abs) << C;
            den_reg <= den_abs;
            neg_reg <= num[NW-1] ^ den[DNW-1];
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
                rem_reg <= rem_reg - dsh_reg;
            q_reg   <= {q_reg[QW-2:0], rem_ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.isx_we)
            ix_reg <= csat;
        if (cmd.isy_we)
            iy_reg <= csat;
        if (cmd.emit)
        begin
            unique case (cmd.kind)
                pec_pkg::KIND_PREV:
                begin
                    ox_reg <= qx_reg;
                    oy_reg <= qy_reg;
                end
                pec_pkg::KIND_CUR:
                begin
                    ox_reg <= vx_reg;
                    oy_reg <= vy_reg;
                end
                pec_pkg::KIND_ISECT:
                begin
                    ox_reg <= ix_reg;
                    oy_reg <= iy_reg;
                end
                default:
                begin
                    ox_reg <= '0;
                    oy_reg <= '0;
                end
            endcase
            has_reg <= (cmd.kind != pec_pkg::KIND_MARK);
            re_reg  <= cmd.run_end;
            pe_reg  <= cmd.poly_end;
        end
    end

    assign stat.seen     = seen_reg;
    assign stat.fin      = fin_reg;
    assign stat.in_p     = ~sp_reg[SW-1];
    assign stat.in_v     = ~sv_reg[SW-1];
    assign stat.in_f     = ~sf_reg[SW-1];
    assign stat.div_done = (cnt_reg == CNW'(QW));
    assign stat.out_free = ~ov_reg | result_ready;

    assign result_valid = ov_reg;
    assign out_x        = ox_reg;
    assign out_y        = oy_reg;
    assign has_vertex   = has_reg;
    assign run_end      = re_reg;
    assign polygon_end  = pe_reg;

endmodule
